// File: rtl/core/isq_pkg.sv
// Shared types, constants and request codes for the indexed sequential search block.
`default_nettype none
package isq_pkg;

	// Default sizes of the two stores.
	localparam int ISQ_MAX_ENTRIES = 1024;
	localparam int ISQ_MAX_BLOCKS  = 32;

	// Request codes carried in req_type.
	localparam logic [1:0] REQ_WRITE_ENTRY = 2'd0;
	localparam logic [1:0] REQ_WRITE_MAX   = 2'd1;
	localparam logic [1:0] REQ_SEARCH      = 2'd2;

	// Configuration register indexes, decoded from paddr[2].
	localparam logic REG_BLOCK_COUNT       = 1'b0;
	localparam logic REG_ENTRIES_PER_BLOCK = 1'b1;

	localparam logic [5:0]  BLOCK_COUNT_RST       = 6'd1;
	localparam logic [10:0] ENTRIES_PER_BLOCK_RST = 11'd1;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [9:0]         slot;
		logic signed [31:0] value;
	} isq_req_t;

	typedef struct packed {
		logic        found;
		logic [10:0] position;
		logic [10:0] probes;
	} isq_rsp_t;

endpackage
`default_nettype wire

// File: rtl/core/indexed_sequential_search.sv
// Top level of the indexed sequential search block: sequencer, registers and the two stores.
`default_nettype none
// Usage:
// A request word is taken when start is high and busy is low. It either writes
// a table entry (slot = position - 1), writes one block maximum (slot = block
// number), or searches for the key in value. Every request produces exactly
// one result word on rsp, marked by a one-cycle pulse on done; the receiver
// cannot stall, so the word must be captured in that cycle.
// Writes and unknown request codes answer in the cycle after acceptance and
// the block is ready again at once. A search holds busy high while a small
// sequencer walks the block maxima and then the chosen block, one store read
// at a time: each probe presents the address (S_BLK_RD or S_ENT_RD), then
// compares against the registered read data (S_BLK_CHK or S_ENT_CHK). The
// single read port of each store is why the probes run one at a time.
// APB writes block_count and entries_per_block at byte addresses 0 and 4;
// the user must write them only while the block is idle, which the block
// does not enforce. Reset sets both to 1 and returns the sequencer to idle;
// the stores are not cleared and must be written before they are searched.
module indexed_sequential_search #(
	parameter int MAX_ENTRIES = isq_pkg::ISQ_MAX_ENTRIES,
	parameter int MAX_BLOCKS  = isq_pkg::ISQ_MAX_BLOCKS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire isq_pkg::isq_req_t req,
	output logic                  done,
	output isq_pkg::isq_rsp_t     rsp,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [2:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic      [31:0]      prdata,
	output logic                  pready
);

	import isq_pkg::*;

	localparam int EA_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int BA_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int SPAN_A = $clog2(MAX_BLOCKS + 1) + 11;
	localparam int SPAN_B = $clog2(MAX_ENTRIES + 1);
	localparam int IW     = ((SPAN_A > SPAN_B) ? SPAN_A : SPAN_B) + 1;
	localparam int BC_CAP = (MAX_BLOCKS > 63) ? 63 : MAX_BLOCKS;

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_BLK_RD  = 5'b00010,
		S_BLK_CHK = 5'b00100,
		S_ENT_RD  = 5'b01000,
		S_ENT_CHK = 5'b10000
	} isq_state_t;

	isq_state_t         state_q;
	logic [5:0]         block_count_q;
	logic [10:0]        epb_q;
	logic signed [31:0] key_q;
	logic [5:0]         b_q;
	logic [10:0]        e_q;
	logic [IW-1:0]      start_q;
	logic [IW-1:0]      idx_q;
	logic               done_q;
	isq_rsp_t           rsp_q;

	logic               accept;
	logic               cfg_wr;
	logic [5:0]         nblk;
	logic [IW-1:0]      idx;
	logic [IW-1:0]      pos_sum;
	logic [10:0]        probe_sum;
	logic               ent_we;
	logic               blk_we;
	logic [EA_W-1:0]    ent_addr;
	logic [BA_W-1:0]    blk_addr;
	logic [31:0]        ent_rdata;
	logic [31:0]        blk_rdata;
	logic [EA_W+9:0]    slot_ent_ext;
	logic [BA_W+9:0]    slot_blk_ext;
	logic [BA_W+5:0]    b_ext;
	logic               slot_ent_ok;
	logic               slot_blk_ok;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign rsp    = rsp_q;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	assign prdata = (paddr[2] == REG_ENTRIES_PER_BLOCK) ? {21'd0, epb_q} : {26'd0, block_count_q};

	// Blocks beyond the maximum store depth are never examined.
	assign nblk = (block_count_q > 6'(BC_CAP)) ? 6'(BC_CAP) : block_count_q;

	assign idx       = start_q + IW'(e_q);
	assign pos_sum   = idx_q + IW'(1);
	assign probe_sum = e_q + 11'(b_q) + 11'd2;

	assign slot_ent_ext = {{EA_W{1'b0}}, req.slot};
	assign slot_blk_ext = {{BA_W{1'b0}}, req.slot};
	assign b_ext        = {{BA_W{1'b0}}, b_q};
	assign slot_ent_ok  = (17'(req.slot) < 17'(MAX_ENTRIES));
	assign slot_blk_ok  = (11'(req.slot) < 11'(MAX_BLOCKS));

	assign ent_we = accept && (req.req_type == REQ_WRITE_ENTRY) && slot_ent_ok;
	assign blk_we = accept && (req.req_type == REQ_WRITE_MAX) && slot_blk_ok;

	assign ent_addr = ent_we ? slot_ent_ext[EA_W-1:0] : idx[EA_W-1:0];
	assign blk_addr = blk_we ? slot_blk_ext[BA_W-1:0] : b_ext[BA_W-1:0];

	isq_ram #(
		.WIDTH(32),
		.DEPTH(MAX_ENTRIES),
		.AW   (EA_W)
	) u_entry_ram (
		.clk  (clk),
		.we   (ent_we),
		.addr (ent_addr),
		.wdata(req.value),
		.rdata(ent_rdata)
	);

	isq_ram #(
		.WIDTH(32),
		.DEPTH(MAX_BLOCKS),
		.AW   (BA_W)
	) u_block_max_ram (
		.clk  (clk),
		.we   (blk_we),
		.addr (blk_addr),
		.wdata(req.value),
		.rdata(blk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= BLOCK_COUNT_RST;
			epb_q         <= ENTRIES_PER_BLOCK_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_BLOCK_COUNT) begin
				block_count_q <= pwdata[5:0];
			end else begin
				epb_q <= pwdata[10:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.req_type == REQ_SEARCH) begin
							state_q <= S_BLK_RD;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_BLK_RD: begin
					if (b_q >= nblk) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_BLK_CHK;
					end
				end
				S_BLK_CHK: begin
					if ($signed(blk_rdata) >= key_q) begin
						state_q <= S_ENT_RD;
					end else begin
						state_q <= S_BLK_RD;
					end
				end
				S_ENT_RD: begin
					if ((e_q >= epb_q) || (idx >= IW'(MAX_ENTRIES))) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_ENT_CHK;
					end
				end
				S_ENT_CHK: begin
					if ($signed(ent_rdata) == key_q) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_ENT_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Search bookkeeping and the result word.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					key_q   <= req.value;
					b_q     <= 6'd0;
					e_q     <= 11'd0;
					start_q <= '0;
					rsp_q   <= '0;
				end
			end
			S_BLK_RD: begin
				rsp_q <= '0;
			end
			S_BLK_CHK: begin
				if ($signed(blk_rdata) < key_q) begin
					b_q     <= b_q + 6'd1;
					start_q <= start_q + IW'(epb_q);
				end
			end
			S_ENT_RD: begin
				idx_q <= idx;
				rsp_q <= '0;
			end
			S_ENT_CHK: begin
				if ($signed(ent_rdata) == key_q) begin
					rsp_q.found    <= 1'b1;
					rsp_q.position <= pos_sum[10:0];
					rsp_q.probes   <= probe_sum;
				end else begin
					e_q <= e_q + 11'd1;
				end
			end
			default: begin
				rsp_q <= '0;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/core/isq_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none
module isq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire
